/* design/bpra_pkg.sv */
// bpra_pkg: shared constants and types of the bitmap row aligner
// used by the channel interfaces, front queue, back engine and top level
`default_nettype none

package bpra_pkg;

    localparam int BPRA_MAX_WIDTH  = 128;
    localparam int BPRA_MAX_HEIGHT = 128;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [7:0] WIDTH_RESET  = 8'd8;
    localparam logic [7:0] HEIGHT_RESET = 8'd8;

    localparam logic [3:0] PIX_LAST  = 4'd7;
    localparam logic [3:0] PIX_SHORT = 4'd8;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

`default_nettype wire

/* design/bpra_in_if.sv */
// bpra_in_if: valid/ready channel carrying one packed input byte per request
// depends on bpra_pkg
`default_nettype none

interface bpra_in_if
    import bpra_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       final_byte;

    modport source (output valid, output packed_byte, output final_byte, input ready);
    modport sink   (input valid, input packed_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* design/bpra_out_if.sv */
// bpra_out_if: valid/ready channel carrying one aligned row byte per request
// depends on bpra_pkg
`default_nettype none

interface bpra_out_if
    import bpra_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] row_byte;
    logic       row_end;
    logic       glyph_end;
    logic       short_data;

    modport source (output valid, output row_byte, output row_end, output glyph_end,
                    output short_data, input ready);
    modport sink   (input valid, input row_byte, input row_end, input glyph_end,
                    input short_data, output ready);
endinterface

`default_nettype wire

/* design/bit_packed_bitmap_row_aligner_top.sv */
// bit_packed_bitmap_row_aligner_top: config registers, front queue and pixel engine
// depends on bpra_pkg, bpra_in_if, bpra_out_if, bpra_front, bpra_back
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    packed_byte[7:0], final_byte
//  o_out     out  valid/ready    row_byte[7:0], row_end, glyph_end, short_data
//  apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
//  one pixel per cycle in the back engine when not stalled; a final byte adds a closing step
//  every pixel yields at most one row byte, so output is at most one byte per cycle
//  a two-entry queue takes new bytes while the engine and output register are busy
//  the engine stalls when the queue is empty or the output register holds a byte not yet taken
//  synchronous active-low reset clears counters, queue and output valid
`default_nettype none

module bit_packed_bitmap_row_aligner_top
    import bpra_pkg::*;
#(
    parameter int MAX_WIDTH  = BPRA_MAX_WIDTH,
    parameter int MAX_HEIGHT = BPRA_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bpra_in_if.sink                    i_in,
    bpra_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [7:0]    r_width, r_height;
    logic [WW-1:0] s_width;
    logic [HW-1:0] s_height;
    logic          s_wr;
    t_reg_idx      s_idx;
    t_head         s_head;
    logic          s_pop;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite && pready;
    assign s_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (s_wr) begin
            unique case (s_idx)
                REG_WIDTH:  r_width  <= pwdata[7:0];
                REG_HEIGHT: r_height <= pwdata[7:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (s_idx)
            REG_WIDTH:  prdata = CFG_DATA_W'(r_width);
            REG_HEIGHT: prdata = CFG_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (r_width == '0) begin
            s_width = WW'(1);
        end else if (9'(r_width) > 9'(MAX_WIDTH)) begin
            s_width = WW'(MAX_WIDTH);
        end else begin
            s_width = WW'(r_width);
        end
        if (r_height == '0) begin
            s_height = HW'(1);
        end else if (9'(r_height) > 9'(MAX_HEIGHT)) begin
            s_height = HW'(MAX_HEIGHT);
        end else begin
            s_height = HW'(r_height);
        end
    end

    bpra_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (s_pop),
        .o_head  (s_head)
    );

    bpra_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (s_width),
        .i_height (s_height),
        .i_head   (s_head),
        .o_pop    (s_pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

/* design/bpra_front.sv */
// bpra_front: input side, a short request queue in front of the pixel engine
// depends on bpra_pkg and bpra_in_if
`default_nettype none

module bpra_front
    import bpra_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bpra_in_if.sink     i_in,
    input  wire logic   i_pop,
    output t_head       o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [NW-1:0]  r_cnt, n_cnt;
    logic           s_push;

    assign i_in.ready = (r_cnt != NW'(QUEUE_DEPTH));
    assign s_push     = i_in.valid && i_in.ready;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (s_push) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (s_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!s_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wptr] <= '{packed_byte: i_in.packed_byte, final_byte: i_in.final_byte};
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with split pointers");

endmodule

`default_nettype wire

/* design/bpra_back.sv */
// bpra_back: pixel engine, one pixel per cycle when not stalled, with the result output register
// depends on bpra_pkg and bpra_out_if
`default_nettype none

module bpra_back
    import bpra_pkg::*;
#(
    parameter int MAX_WIDTH  = BPRA_MAX_WIDTH,
    parameter int MAX_HEIGHT = BPRA_MAX_HEIGHT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  i_width,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] i_height,
    input  wire t_head                           i_head,
    output logic                                 o_pop,
    bpra_out_if.source                           o_out
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CW1 = CW + 1;
    localparam int RW1 = RW + 1;

    logic [7:0]    r_acc, n_acc;
    logic [2:0]    r_nbits, n_nbits;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_done, n_done;
    logic [3:0]    r_pix, n_pix;

    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_ore, r_oge, r_osd;

    logic           s_go, s_short, s_bit, s_emit;
    logic [7:0]     s_acc;
    logic [CW1-1:0] s_col_inc;
    logic [RW1-1:0] s_row_inc;
    logic           s_row_done, s_glyph_done;

    assign s_go    = i_head.valid && (!r_ov || o_out.ready);
    assign s_short = (r_pix == PIX_SHORT);
    assign s_bit   = i_head.item.packed_byte[~r_pix[2:0]];
    assign s_acc   = r_acc | (8'(s_bit) << ~r_nbits);

    assign s_col_inc    = CW1'(r_col) + 1'b1;
    assign s_row_inc    = RW1'(r_row) + 1'b1;
    assign s_row_done   = (s_col_inc >= CW1'(i_width));
    assign s_glyph_done = s_row_done && (s_row_inc >= RW1'(i_height));

    assign s_emit = !r_done && (s_short || (r_nbits == 3'd7) || s_row_done);
    assign o_pop  = s_go && (s_short || ((r_pix == PIX_LAST) && !i_head.item.final_byte));

    always_comb begin
        n_acc   = r_acc;
        n_nbits = r_nbits;
        n_col   = r_col;
        n_row   = r_row;
        n_done  = r_done;
        n_pix   = r_pix;
        if (s_go) begin
            if (s_short) begin
                n_acc   = '0;
                n_nbits = '0;
                n_col   = '0;
                n_row   = '0;
                n_done  = 1'b0;
                n_pix   = '0;
            end else begin
                if (r_pix == PIX_LAST) begin
                    n_pix = i_head.item.final_byte ? PIX_SHORT : '0;
                end else begin
                    n_pix = r_pix + 1'b1;
                end
                if (!r_done) begin
                    if (s_glyph_done) begin
                        n_acc   = '0;
                        n_nbits = '0;
                        n_col   = '0;
                        n_row   = '0;
                        n_done  = 1'b1;
                    end else begin
                        n_col = s_row_done ? '0 : CW'(s_col_inc);
                        n_row = s_row_done ? RW'(s_row_inc) : r_row;
                        if (s_emit) begin
                            n_acc   = '0;
                            n_nbits = '0;
                        end else begin
                            n_acc   = s_acc;
                            n_nbits = r_nbits + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_nbits <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_done  <= 1'b0;
            r_pix   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_nbits <= n_nbits;
            r_col   <= n_col;
            r_row   <= n_row;
            r_done  <= n_done;
            r_pix   <= n_pix;
            if (s_go && s_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && s_emit) begin
            if (s_short) begin
                r_ob  <= r_acc;
                r_ore <= 1'b0;
                r_oge <= 1'b1;
                r_osd <= 1'b1;
            end else begin
                r_ob  <= s_acc;
                r_ore <= s_row_done;
                r_oge <= s_glyph_done;
                r_osd <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.row_byte   = r_ob;
    assign o_out.row_end    = r_ore;
    assign o_out.glyph_end  = r_oge;
    assign o_out.short_data = r_osd;

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc == '0 && r_nbits == '0 && r_col == '0 && r_row == '0))
        else $error("state not cleared after glyph end");

    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix <= PIX_SHORT)
        else $error("pixel index out of range");

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_pix == PIX_LAST || r_pix == PIX_SHORT))
        else $error("request released mid byte");

    a_glyph_end_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && !s_short && s_emit && s_glyph_done) |=> (r_done || r_pix == '0))
        else $error("glyph end without completion");

endmodule

`default_nettype wire

/* bench/bpra_row_checker.sv */
// bpra_row_checker: watches the byte channels and config writes of the row aligner,
// predicts the aligned row bytes and compares them, counting mismatches
// depends on bpra_pkg, bpra_in_if, bpra_out_if
module bpra_row_checker
    import bpra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpra_in_if                    i_in,
    bpra_out_if                   o_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output int                    o_pending,
    output int                    o_failures
);

    typedef struct packed {
        logic [7:0] row_byte;
        logic       row_end;
        logic       glyph_end;
        logic       short_data;
    } row_result_t;

    row_result_t rows_due[$];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [7:0]  pix_acc;
    int          pix_count;
    int          col_count;
    int          row_count;
    logic        glyph_closed;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_failures < 40) begin
            $display("row mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
        end
        o_failures++;
    endtask

    function automatic void clear_glyph();
        pix_acc      = '0;
        pix_count    = 0;
        col_count    = 0;
        row_count    = 0;
        glyph_closed = 1'b0;
    endfunction

    function automatic void align_byte(input logic [7:0] data, input logic last);
        int   w;
        int   h;
        logic row_done;
        logic glyph_done;
        // zero acts as one, oversize clips to the maximum
        w = (width_reg == 0) ? 1 : (width_reg > BPRA_MAX_WIDTH) ? BPRA_MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > BPRA_MAX_HEIGHT) ? BPRA_MAX_HEIGHT : height_reg;
        for (int i = 7; i >= 0; i--) begin
            if (!glyph_closed) begin
                pix_acc[7 - pix_count] = data[i];
                pix_count++;
                row_done   = (col_count + 1 >= w);
                col_count  = row_done ? 0 : col_count + 1;
                glyph_done = 1'b0;
                if (row_done) begin
                    row_count++;
                    glyph_done = (row_count >= h);
                end
                if (pix_count == 8 || row_done) begin
                    rows_due.push_back(row_result_t'{pix_acc, row_done, glyph_done, 1'b0});
                    pix_acc   = '0;
                    pix_count = 0;
                end
                if (glyph_done) begin
                    clear_glyph();
                    glyph_closed = 1'b1;
                end
            end
        end
        if (last) begin
            // data ran out before the last row
            if (!glyph_closed) begin
                rows_due.push_back(row_result_t'{pix_acc, 1'b0, 1'b1, 1'b1});
            end
            clear_glyph();
        end
    endfunction

    always @(posedge i_clk) begin
        row_result_t seen;
        row_result_t want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            clear_glyph();
            rows_due.delete();
            o_failures = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_ADDR_W-1:2]))
                    REG_WIDTH:  width_reg  = i_pwdata[7:0];
                    REG_HEIGHT: height_reg = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                align_byte(i_in.packed_byte, i_in.final_byte);
            end
            if (o_out.valid && o_out.ready) begin
                seen = row_result_t'{o_out.row_byte, o_out.row_end, o_out.glyph_end,
                                     o_out.short_data};
                if (rows_due.size() == 0) begin
                    report_mismatch("row byte with nothing due", seen, 0);
                end else begin
                    want = rows_due.pop_front();
                    if (seen.row_byte != want.row_byte) begin
                        report_mismatch("row_byte", seen.row_byte, want.row_byte);
                    end
                    if (seen.row_end != want.row_end) begin
                        report_mismatch("row_end", seen.row_end, want.row_end);
                    end
                    if (seen.glyph_end != want.glyph_end) begin
                        report_mismatch("glyph_end", seen.glyph_end, want.glyph_end);
                    end
                    if (seen.short_data != want.short_data) begin
                        report_mismatch("short_data", seen.short_data, want.short_data);
                    end
                end
            end
        end
        o_pending <= rows_due.size();
    end

endmodule

/* bench/bit_packed_bitmap_row_aligner_top_tb.sv */
// bit_packed_bitmap_row_aligner_top_tb: drives glyph byte streams, config writes and
// random stalls into the row aligner; checking is done by bpra_row_checker
// depends on bpra_pkg, bpra_in_if, bpra_out_if, bpra_row_checker and the block itself
module bit_packed_bitmap_row_aligner_top_tb;
    import bpra_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 400;
    localparam logic [63:0] EDGE_GLYPH = 64'hFF00_AA55_8001_7FFE;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic                  pready;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  hold_request;
    int                    rows_pending;
    int                    failures;
    int                    items_sent;
    int                    idle_cycles;
    bit                    sender_calm;

    bpra_in_if  in_ch();
    bpra_out_if out_ch();

    bit_packed_bitmap_row_aligner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpra_row_checker row_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_pending  (rows_pending),
        .o_failures (failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) gap_len = 0;
        else if (r < 85) gap_len = $urandom_range(1, 3);
        else if (r < 97) gap_len = $urandom_range(4, 12);
        else gap_len = $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = sender_calm ? 0 : gap_len();
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.packed_byte <= data;
        in_ch.final_byte  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random back-pressure, one long hold when asked
    initial begin
        int gap;
        bit calm;
        bit held;
        gap  = 0;
        calm = 1'b0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !held) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if ($urandom_range(0, 63) == 0) calm = ($urandom_range(0, 2) == 0);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                gap--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm) gap = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] cfg_w;
        logic [7:0] cfg_h;
        logic       last;
        int         w_eff;
        int         h_eff;
        int         glyph_bytes;
        int         count;
        int         kind;
        int         phase;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.packed_byte <= '0;
        in_ch.final_byte  <= 1'b0;
        hold_request      <= 1'b0;
        sender_calm        = 1'b0;
        items_sent         = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size 8x8: full glyph ending with the final byte
        for (int k = 0; k < 8; k++) send_byte(EDGE_GLYPH[63 - 8*k -: 8], k == 7);
        // short glyph, then a lone final byte
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h5A, 1'b1);
        // complete glyph followed by trailing bytes
        for (int k = 0; k < 8; k++) send_byte(~EDGE_GLYPH[63 - 8*k -: 8], 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b1);

        // long output hold while input keeps coming
        sender_calm = 1'b1;
        hold_request <= 1'b1;
        for (int k = 0; k < 24; k++) send_byte($urandom_range(0, 255), k % 8 == 7);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain();
            case (phase)
                0: begin cfg_w = 8'd0;   cfg_h = 8'd255; end
                1: begin cfg_w = 8'd255; cfg_h = 8'd0;   end
                2: begin cfg_w = 8'd128; cfg_h = 8'd128; end
                3: begin cfg_w = 8'd1;   cfg_h = 8'd1;   end
                4: begin cfg_w = 8'd255; cfg_h = 8'd255; end
                5: begin cfg_w = 8'd1;   cfg_h = 8'd128; end
                6: begin cfg_w = 8'd128; cfg_h = 8'd1;   end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        cfg_w = $urandom_range(0, 255);
                        cfg_h = $urandom_range(0, 3);
                    end else begin
                        cfg_w = $urandom_range(1, 20);
                        cfg_h = $urandom_range(1, 8);
                    end
                end
            endcase
            phase++;
            reg_write(REG_WIDTH, cfg_w);
            reg_write(REG_HEIGHT, cfg_h);
            w_eff = (cfg_w == 0) ? 1 : (cfg_w > BPRA_MAX_WIDTH) ? BPRA_MAX_WIDTH : cfg_w;
            h_eff = (cfg_h == 0) ? 1 : (cfg_h > BPRA_MAX_HEIGHT) ? BPRA_MAX_HEIGHT : cfg_h;
            glyph_bytes = (w_eff * h_eff + 7) / 8;
            repeat ($urandom_range(1, 4)) begin
                sender_calm = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 19);
                if (glyph_bytes > 48 && kind < 18) kind = 14;
                if (kind < 14) count = glyph_bytes;
                else if (kind < 16) count = $urandom_range(1, glyph_bytes < 24 ? glyph_bytes : 24);
                else if (kind < 18) count = glyph_bytes + $urandom_range(1, 3);
                else if (kind == 18) count = $urandom_range(1, glyph_bytes < 22 ? glyph_bytes + 2 : 24);
                else count = $urandom_range(1, 6);
                for (int k = 0; k < count; k++) begin
                    // no final on an unterminated run, random finals on noise
                    if (kind == 19) last = $urandom_range(0, 1);
                    else if (kind == 18) last = 1'b0;
                    else last = (k == count - 1);
                    send_byte($urandom_range(0, 255), last);
                end
            end
        end
        drain();
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* bit_packed_bitmap_row_aligner_top.f */
design/bpra_pkg.sv
design/bpra_in_if.sv
design/bpra_out_if.sv
design/bpra_front.sv
design/bpra_back.sv
design/bit_packed_bitmap_row_aligner_top.sv
bench/bpra_row_checker.sv
bench/bit_packed_bitmap_row_aligner_top_tb.sv
